// ===== rtl/core/mowf_pkg.sv =====
// ----------------------------------------------------------------------------
// mowf_pkg
// shared types and constants for the median / weighted window filter
// ----------------------------------------------------------------------------
package mowf_pkg;

  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned WINDOW_TAPS = 3;
  localparam int unsigned WSUM_W      = 13;
  localparam int unsigned QUART_W     = WSUM_W - 2;
  localparam int unsigned DIV3_SHIFT  = 11;
  localparam int unsigned DIV3_RECIP  = 683;
  localparam int unsigned DIV3_PROD_W = QUART_W + 10;

  localparam logic MODE_MEDIAN   = 1'b0;
  localparam logic MODE_WEIGHTED = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t newest;
    sample_t middle;
    sample_t oldest;
  } window_t;

endpackage

// ===== rtl/core/median_or_weighted_window_filter_unit.sv =====
// ----------------------------------------------------------------------------
// median_or_weighted_window_filter_unit
// three-tap window filter for 10-bit adc codes, median or weighted mode
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one sample request; each accepted sample is
//   pushed into the window (newest first) and gives exactly one
//   out_filtered result on out_valid/out_ready.
//   cfg_wr_en writes cfg_wr_data into the mode register (0 median,
//   1 weighted); write it only while no request is in flight.
//   An accepted sample passes through the window register and then the
//   result register before it shows on out_valid.
//   Throughput: one sample per cycle unless the receiver stalls; the
//   compare network and the constant divide sit between these registers.
//   When the receiver stalls, the result register holds and the window
//   register takes one more sample; in_ready drops only when both are full.
//   Reset clears the window taps to zero, the mode to median and both
//   valid flags; the zero taps take part as ordinary samples.
// ----------------------------------------------------------------------------
module median_or_weighted_window_filter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mowf_pkg::sample_t   in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output mowf_pkg::sample_t   out_filtered,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  mowf_pkg::window_t win_r;
  mowf_pkg::window_t win_nxt;
  logic              win_valid_r;
  logic              win_valid_nxt;
  logic              mode_r;
  logic              mode_nxt;
  mowf_pkg::sample_t out_filtered_r;
  mowf_pkg::sample_t out_filtered_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;

  mowf_pkg::sample_t median;
  mowf_pkg::sample_t wavg;
  logic              in_acc;
  logic              out_load;

  mowf_median u_median (
    .win    (win_r),
    .median (median)
  );

  mowf_wavg u_wavg (
    .win  (win_r),
    .wavg (wavg)
  );

  assign out_load = win_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !win_valid_r || out_load;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    win_nxt          = win_r;
    win_valid_nxt    = win_valid_r;
    mode_nxt         = mode_r;
    out_filtered_nxt = out_filtered_r;
    out_valid_nxt    = out_valid_r;
    if (cfg_wr_en) begin
      mode_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_filtered_nxt = (mode_r == mowf_pkg::MODE_WEIGHTED) ? wavg : median;
      out_valid_nxt    = 1'b1;
      win_valid_nxt    = 1'b0;
    end
    if (in_acc) begin
      win_nxt.newest = in_sample;
      win_nxt.middle = win_r.newest;
      win_nxt.oldest = win_r.middle;
      win_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      win_valid_r <= 1'b0;
      mode_r      <= mowf_pkg::MODE_MEDIAN;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      win_valid_r <= win_valid_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_filtered_r <= out_filtered_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !win_valid_r |-> in_ready)
    else $error("in_ready low with empty window stage");

  a_acc_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> win_valid_r)
    else $error("accepted sample not held in window stage");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load lost");

  a_median_tap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (mode_r == mowf_pkg::MODE_MEDIAN)) |=>
      ((out_filtered_r == $past(win_r.newest)) ||
       (out_filtered_r == $past(win_r.middle)) ||
       (out_filtered_r == $past(win_r.oldest))))
    else $error("median result is not a window tap");

  a_wavg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (mode_r == mowf_pkg::MODE_WEIGHTED)) |=>
      (out_filtered_r[mowf_pkg::SAMPLE_W-1] == 1'b0))
    else $error("weighted result out of range");

endmodule

// ===== rtl/core/mowf_median.sv =====
// ----------------------------------------------------------------------------
// mowf_median
// median of the three window taps by a compare network
// ----------------------------------------------------------------------------
module mowf_median (
  input  mowf_pkg::window_t win,
  output mowf_pkg::sample_t median
);

  mowf_pkg::sample_t lo;
  mowf_pkg::sample_t hi;

  always_comb begin
    if (win.newest < win.middle) begin
      lo = win.newest;
      hi = win.middle;
    end else begin
      lo = win.middle;
      hi = win.newest;
    end
    if (win.oldest <= lo) begin
      median = lo;
    end else if (win.oldest >= hi) begin
      median = hi;
    end else begin
      median = win.oldest;
    end
  end

endmodule

// ===== rtl/core/mowf_wavg.sv =====
// ----------------------------------------------------------------------------
// mowf_wavg
// weighted window average, floor((n + 2m + 3o) / 12)
// ----------------------------------------------------------------------------
module mowf_wavg (
  input  mowf_pkg::window_t win,
  output mowf_pkg::sample_t wavg
);

  logic [mowf_pkg::WSUM_W-1:0]      wsum;
  logic [mowf_pkg::QUART_W-1:0]     quart;
  logic [mowf_pkg::DIV3_PROD_W-1:0] prod;

  always_comb begin
    wsum = {3'b000, win.newest}
         + {2'b00, win.middle, 1'b0}
         + {2'b00, win.oldest, 1'b0}
         + {3'b000, win.oldest};
    // divide by 4 then by 3 through the reciprocal, exact below 2048
    quart = wsum[mowf_pkg::WSUM_W-1:2];
    prod  = {{(mowf_pkg::DIV3_PROD_W-mowf_pkg::QUART_W){1'b0}}, quart}
          * mowf_pkg::DIV3_PROD_W'(mowf_pkg::DIV3_RECIP);
    wavg  = prod[mowf_pkg::DIV3_SHIFT +: mowf_pkg::SAMPLE_W];
  end

endmodule
